[rtl/bbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bimodal branch predictor package
// Shared types, counter state codes and the 2-bit counter update function.
// ----------------------------------------------------------------------------
package bbp_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 1024;
   localparam int PC_W  = 32;
   localparam int CNT_W = 32;

   // Two-bit saturating counter states.
   localparam logic [1:0] CTR_STRONG_NT = 2'd0;
   localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
   localparam logic [1:0] CTR_WEAK_T    = 2'd2;
   localparam logic [1:0] CTR_STRONG_T  = 2'd3;

   // Transaction kinds.
   localparam logic ACT_PREDICT = 1'b0;
   localparam logic ACT_UPDATE  = 1'b1;

   typedef struct packed {
      logic            action;
      logic [PC_W-1:0] pc;
      logic            taken;
   } bbp_req_type;

   typedef struct packed {
      logic             predict_taken;
      logic [CNT_W-1:0] access_count;
      logic [CNT_W-1:0] mispredict_count;
   } bbp_rsp_type;

   // Counter training. A not-taken outcome drops a strong-taken counter to
   // weak-taken and anything else to strong-not-taken; a taken outcome lifts
   // strong-not-taken to weak-not-taken and anything else to strong-taken.
   function automatic logic [1:0] ctr_next(input logic [1:0] old_state,
                                           input logic       taken);
      logic [1:0] result;
      if (taken) begin
         result = (old_state == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
      end else begin
         result = (old_state == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
      end
      return result;
   endfunction

endpackage

[rtl/bbp_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bimodal branch predictor counter table
// Single-port-write, single-read synchronous memory of 2-bit counters with a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module bbp_table
   import bbp_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [1:0]       rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [1:0]       wr_data,
   output logic             clr_busy
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [1:0]       ctr_mem_ff [TABLE_ENTRIES];
   logic [1:0]       rd_data_ff;
   logic             clr_busy_ff;
   logic [IDX_W-1:0] clr_idx_ff;

   // The sweep writes one entry per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         ctr_mem_ff[clr_idx_ff] <= CTR_STRONG_NT;
      end else if (wr_en) begin
         ctr_mem_ff[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ctr_mem_ff[rd_idx];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

[rtl/bimodal_branch_predictor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bimodal branch predictor unit
// Table of 2-bit counters indexed by branch word address, with lookup and
// mispredict counters.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on req_* carries an action (predict or update), the
// branch byte address and, for an update, the actual outcome. Each request
// produces exactly one response transaction on rsp_* with the prediction
// taken from the counter before the request, the running lookup count and
// the running mispredict count. Address bits 1..0 never affect the index.
// Flow: a request accepted at one edge has its counter read from the table
// memory at that edge. Once the response register is free or being emptied,
// the request commits: the counter is trained, the counts are updated and
// the response register is loaded, raising rsp_valid. Throughput is one
// transaction per cycle while responses are taken; the registered read is
// hidden by forwarding a write to the same entry in the same cycle.
// After reset the table is swept to strong-not-taken, one entry per cycle,
// so req_ready stays low until the sweep ends. When the receiver stalls,
// the response register holds, the one request in flight waits behind it,
// and req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module bimodal_branch_predictor_unit
   import bbp_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bbp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bbp_rsp_type rsp_data
);

   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);

   // Read stage: the request whose counter is arriving from the table.
   logic             s1_valid_ff;
   bbp_req_type      s1_req_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             fwd_hit_ff;
   logic [1:0]       fwd_data_ff;

   logic             rsp_valid_ff;
   bbp_rsp_type      rsp_data_ff;
   logic [CNT_W-1:0] acc_cnt_ff;
   logic [CNT_W-1:0] mis_cnt_ff;

   logic             req_fire;
   logic             commit;
   logic             wr_en;
   logic [IDX_W-1:0] req_idx;
   logic [1:0]       tbl_rd_data;
   logic [1:0]       old_state;
   logic [1:0]       new_state;
   logic             guess;
   logic             clr_busy;
   logic [CNT_W-1:0] acc_cnt_in;
   logic [CNT_W-1:0] mis_cnt_in;

   // The word address is masked to the table size, so a table size that is
   // not a power of two leaves some entries unused.
   assign req_idx = req_data.pc[IDX_W+1:2] & IDX_MASK;

   // The request in the read stage completes once the response register is
   // free or being emptied in this cycle.
   assign commit    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy && (!s1_valid_ff || commit);
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = commit && (s1_req_ff.action == ACT_UPDATE);

   // A write landing in the same cycle as the read of the same entry is
   // forwarded, since the memory returns the old contents.
   assign old_state = fwd_hit_ff ? fwd_data_ff : tbl_rd_data;
   assign guess     = old_state[1];
   assign new_state = ctr_next(old_state, s1_req_ff.taken);

   always_comb begin
      acc_cnt_in = acc_cnt_ff;
      mis_cnt_in = mis_cnt_ff;
      if (s1_req_ff.action == ACT_PREDICT) begin
         acc_cnt_in = acc_cnt_ff + 1'b1;
      end else if (s1_req_ff.taken != guess) begin
         mis_cnt_in = mis_cnt_ff + 1'b1;
      end
   end

   bbp_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_idx  (req_idx),
      .rd_data (tbl_rd_data),
      .wr_en   (wr_en),
      .wr_idx  (s1_idx_ff),
      .wr_data (new_state),
      .clr_busy(clr_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (commit) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff   <= req_data;
         s1_idx_ff   <= req_idx;
         fwd_hit_ff  <= wr_en && (s1_idx_ff == req_idx);
         fwd_data_ff <= new_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_cnt_ff   <= '0;
         mis_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         acc_cnt_ff   <= acc_cnt_in;
         mis_cnt_ff   <= mis_cnt_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff.predict_taken    <= guess;
         rsp_data_ff.access_count     <= acc_cnt_in;
         rsp_data_ff.mispredict_count <= mis_cnt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No request may enter while the table is still being cleared.
   a_no_accept_in_clear: assert property (
      @(posedge clock) disable iff (reset) clr_busy |-> !req_fire
   ) else $error("request accepted during table clear");

   // A committed lookup advances the lookup count by exactly one.
   a_lookup_count: assert property (
      @(posedge clock) disable iff (reset)
      (commit && s1_req_ff.action == ACT_PREDICT)
         |=> (acc_cnt_ff == $past(acc_cnt_ff) + 1'b1) && $stable(mis_cnt_ff)
   ) else $error("lookup count did not advance correctly");

   // The mispredict count only moves on a committed update.
   a_miss_count_hold: assert property (
      @(posedge clock) disable iff (reset)
      !(commit && s1_req_ff.action == ACT_UPDATE) |=> $stable(mis_cnt_ff)
   ) else $error("mispredict count changed without an update");

   // A response is loaded exactly when a request leaves the read stage.
   a_rsp_follows_commit: assert property (
      @(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff
   ) else $error("committed request produced no response");

endmodule
